/* src/compact_target_retarget_top_assert.svh */
// Assertion macros for the compact target retarget block.
// Used by the port checker; needs i_clk and i_rst_n in the using scope.
`ifndef COMPACT_TARGET_RETARGET_TOP_ASSERT_SVH
`define COMPACT_TARGET_RETARGET_TOP_ASSERT_SVH

// same-cycle implication
`define CCTR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CCTR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/cctr_pkg.sv */
// Shared types and constants for the compact target retarget block.
// No dependencies.
package cctr_pkg;

    localparam int TARGET_BYTES_DEF = 32;
    localparam int OFF_W            = 6;   // byte offset, covers targets up to 64 bytes
    localparam int MANT_W           = 23;
    localparam int SPAN_W           = 34;
    localparam int PROD_W           = MANT_W + SPAN_W;
    localparam int LEN_W            = 6;   // bit length of the product
    localparam int NUM_W            = 64;  // dividend width
    localparam int DIV_W            = 32;
    localparam int FIFO_DEPTH       = 2;
    localparam int MIN_LEN          = 49;  // product bits wanted before division
    localparam logic [31:0] TS_RESET  = 32'd1209600;
    localparam logic [22:0] MANT_MASK = 23'h7fffff;
    localparam logic [7:0]  EXP_DIRECT = 8'd3;
    localparam logic        REG_PERIOD_LEN = 1'b0;

    typedef struct packed {
        logic              ovf;
        logic              zero;
        logic [MANT_W-1:0] base;
        logic [OFF_W-1:0]  off;
        logic [SPAN_W-1:0] span;
        logic [DIV_W-1:0]  div;
    } t_job;

    typedef struct packed {
        logic             ovf;
        logic             zero;
        logic [OFF_W-1:0] jb;
    } t_tag;

endpackage

/* src/cctr_front.sv */
// Front end: input handshake, span clamp and compact expansion.
// Depends on cctr_pkg.
module cctr_front #(
    parameter int TARGET_BYTES = cctr_pkg::TARGET_BYTES_DEF
) (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [31:0]       i_measured_timespan,
    input  logic [31:0]       i_prev_compact,
    input  logic [31:0]       i_div,
    input  logic              i_full,
    output logic              o_push,
    output cctr_pkg::t_job    o_job
);
    localparam logic [7:0] TB8 = 8'(TARGET_BYTES);

    logic [7:0]                  expo;
    logic [cctr_pkg::MANT_W-1:0] mant;
    logic [cctr_pkg::SPAN_W-1:0] lo, hi, s;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        expo = i_prev_compact[31:24];
        mant = i_prev_compact[22:0] & cctr_pkg::MANT_MASK;
        lo   = {2'b00, i_div[31:2]};
        hi   = {i_div, 2'b00};
        s    = {2'b00, i_measured_timespan};
        o_job.ovf  = expo > TB8;
        o_job.zero = (expo > TB8) || (i_div == '0);
        o_job.div  = i_div;
        if (s < lo)
            o_job.span = lo;
        else if (s > hi)
            o_job.span = hi;
        else
            o_job.span = s;
        if (expo <= cctr_pkg::EXP_DIRECT) begin
            o_job.base = mant >> {2'(2'd3 - expo[1:0]), 3'b000};
            o_job.off  = '0;
        end else begin
            o_job.base = mant;
            o_job.off  = cctr_pkg::OFF_W'(expo - cctr_pkg::EXP_DIRECT);
        end
    end
endmodule

/* src/cctr_fifo.sv */
// Short job queue between front and back end.
// Depends on cctr_pkg.
module cctr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cctr_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output cctr_pkg::t_job o_job
);
    localparam int PW = $clog2(cctr_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(cctr_pkg::FIFO_DEPTH + 1);

    cctr_pkg::t_job r_mem [cctr_pkg::FIFO_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full     = r_cnt == CW'(cctr_pkg::FIFO_DEPTH);
    assign o_nonempty = r_cnt != '0;
    assign o_job      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= (r_wp == PW'(cctr_pkg::FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)
                r_rp <= (r_rp == PW'(cctr_pkg::FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end
endmodule

/* src/cctr_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cctr_pkg.
module cctr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [cctr_pkg::NUM_W-1:0]  i_num,
    input  logic [cctr_pkg::DIV_W-1:0]  i_div,
    input  cctr_pkg::t_tag              i_tag,
    output logic                        o_vld,
    output logic [cctr_pkg::NUM_W-1:0]  o_quo,
    output cctr_pkg::t_tag              o_tag
);
    localparam int S  = cctr_pkg::NUM_W;
    localparam int DW = cctr_pkg::DIV_W;

    logic [S-1:0]          r_vld;
    logic [DW-1:0]         r_rem [S];
    logic [S-1:0]          r_w   [S];
    logic [DW-1:0]         r_div [S];
    cctr_pkg::t_tag        r_tag [S];

    for (genvar g = 0; g < S; g++) begin : g_stage
        logic           a_vld;
        logic [DW-1:0]  a_rem, a_div;
        logic [S-1:0]   a_w;
        cctr_pkg::t_tag a_tag;
        logic [DW:0]    trial;
        logic           ge;

        if (g == 0) begin : g_first
            assign a_vld = i_vld;
            assign a_rem = '0;
            assign a_w   = i_num;
            assign a_div = i_div;
            assign a_tag = i_tag;
        end else begin : g_next
            assign a_vld = r_vld[g-1];
            assign a_rem = r_rem[g-1];
            assign a_w   = r_w[g-1];
            assign a_div = r_div[g-1];
            assign a_tag = r_tag[g-1];
        end

        always_comb begin
            trial = {a_rem, a_w[S-1]};
            ge    = trial >= {1'b0, a_div};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? DW'(trial - {1'b0, a_div}) : trial[DW-1:0];
                r_w[g]   <= {a_w[S-2:0], ge};
                r_div[g] <= a_div;
                r_tag[g] <= a_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_vld[g] <= 1'b0;
            else if (i_en)
                r_vld[g] <= a_vld;
        end
    end

    assign o_vld = r_vld[S-1];
    assign o_quo = r_w[S-1];
    assign o_tag = r_tag[S-1];
endmodule

/* src/cctr_back.sv */
// Back end: multiply, dividend alignment, divide, compact encoding.
// Depends on cctr_pkg and cctr_div.
module cctr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_vld,
    input  cctr_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [31:0]    o_next_compact,
    output logic           o_overflow
);
    localparam int PW = cctr_pkg::PROD_W;
    localparam int OW = cctr_pkg::OFF_W;
    localparam int NW = cctr_pkg::NUM_W;

    logic adv;

    // stage 1: product
    logic           r1_vld;
    logic [PW-1:0]  r1_prod;
    logic [OW-1:0]  r1_off;
    logic [31:0]    r1_div;
    logic           r1_ovf, r1_zero;
    // stage 2: alignment choice
    logic           r2_vld;
    logic [PW-1:0]  r2_prod;
    logic [2:0]     r2_ub;
    logic [OW-1:0]  r2_jb;
    logic [31:0]    r2_div;
    logic           r2_ovf, r2_zero;
    // stage 3: dividend
    logic           r3_vld;
    logic [NW-1:0]  r3_num;
    logic [31:0]    r3_div;
    cctr_pkg::t_tag r3_tag;

    logic [cctr_pkg::LEN_W-1:0] plen;
    logic [OW-1:0]  ubx;
    logic [2:0]     ub;

    logic           d_vld;
    logic [NW-1:0]  quo;
    cctr_pkg::t_tag d_tag;

    logic [2:0]     top;
    logic           nz, pad;
    logic [79:0]    wide;
    logic [23:0]    w3, mant;
    logic [7:0]     len;
    logic [31:0]    enc;

    logic           r_out_vld, r_ovf;
    logic [31:0]    r_next;

    assign adv   = !r_out_vld || i_out_ready;
    assign o_pop = adv && i_job_vld;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_prod <= PW'(i_job.base) * PW'(i_job.span);
            r1_off  <= i_job.off;
            r1_div  <= i_job.div;
            r1_ovf  <= i_job.ovf;
            r1_zero <= i_job.zero;
        end
    end

    // product bit length; keep at least MIN_LEN bits if the offset allows
    always_comb begin
        plen = '0;
        for (int i = 0; i < PW; i++)
            if (r1_prod[i])
                plen = cctr_pkg::LEN_W'(i + 1);
        if (plen >= cctr_pkg::LEN_W'(cctr_pkg::MIN_LEN))
            ub = '0;
        else
            ub = 3'((cctr_pkg::LEN_W'(cctr_pkg::MIN_LEN + 7) - plen) >> 3);
        ubx = {{(OW-3){1'b0}}, ub};
        if (ubx > r1_off)
            ubx = r1_off;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_prod <= r1_prod;
            r2_ub   <= ubx[2:0];
            r2_jb   <= r1_off - ubx;
            r2_div  <= r1_div;
            r2_ovf  <= r1_ovf;
            r2_zero <= r1_zero;
        end
    end

    // floor((P + d - 1) / (d * 2^j)) == floor((M*2^u + ((d-1) >> j)) / d)
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_num      <= (NW'(r2_prod) << {r2_ub, 3'b000})
                         + NW'((r2_div - 32'd1) >> {r2_jb, 3'b000});
            r3_div      <= r2_div;
            r3_tag.ovf  <= r2_ovf;
            r3_tag.zero <= r2_zero;
            r3_tag.jb   <= r2_jb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_job_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    cctr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r3_vld),
        .i_num   (r3_num),
        .i_div   (r3_div),
        .i_tag   (r3_tag),
        .o_vld   (d_vld),
        .o_quo   (quo),
        .o_tag   (d_tag)
    );

    // encode: leading byte of the quotient word, low bytes read as zero
    always_comb begin
        top = '0;
        nz  = 1'b0;
        for (int i = 0; i < NW / 8; i++)
            if (quo[8*i +: 8] != 8'h00) begin
                top = 3'(i);
                nz  = 1'b1;
            end
        wide = {quo, 16'h0000};
        w3   = 24'(wide >> {top, 3'b000});
        pad  = w3[23];
        mant = pad ? {8'h00, w3[23:8]} : w3;
        len  = 8'(d_tag.jb) + 8'(top) + 8'd1 + 8'(pad);
        enc  = (d_tag.zero || !nz) ? 32'h0 : {len, mant};
    end

    always_ff @(posedge i_clk) begin
        if (adv && d_vld) begin
            r_next <= enc;
            r_ovf  <= d_tag.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_vld <= 1'b0;
        else if (adv)
            r_out_vld <= d_vld;
    end

    assign o_out_valid    = r_out_vld;
    assign o_next_compact = r_next;
    assign o_overflow     = r_ovf;
endmodule

/* src/compact_target_retarget_top.sv */
// Top level of the compact target retarget block: APB register and pipeline.
// Depends on cctr_pkg, cctr_front, cctr_fifo, cctr_back.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one word: measured timespan
//   and previous compact target. Output channel (o_out_valid/i_out_ready)
//   gives one word per input: next compact target and overflow flag.
//   The period length register sits at APB byte address 0 (reset 1209600);
//   write it only while the block is idle. pready is tied high.
// Pipeline: the queue, then multiply, alignment, dividend build, a
//   64-stage divider with one quotient bit per stage, and the output
//   register.
// Throughput: one word per cycle unless stalled; the divider is pipelined.
// Reset: synchronous active-low i_rst_n empties the queue and pipeline
//   and restores the period length.
// Stall: when the receiver holds i_out_ready low the back end freezes
//   with the result held; the front keeps accepting until the two-entry
//   queue is full, then drops o_in_ready.
module compact_target_retarget_top #(
    parameter int TARGET_BYTES = cctr_pkg::TARGET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_measured_timespan,
    input  logic [31:0] i_prev_compact,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_next_compact,
    output logic        o_overflow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0]    r_ts;
    logic           push, full, pop, nonempty;
    cctr_pkg::t_job f_job, q_job;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cctr_pkg::REG_PERIOD_LEN) ? r_ts : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ts <= cctr_pkg::TS_RESET;
        else if (psel && penable && pwrite && pready
                 && paddr[2] == cctr_pkg::REG_PERIOD_LEN)
            r_ts <= pwdata;
    end

    cctr_front #(.TARGET_BYTES(TARGET_BYTES)) u_front (
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_measured_timespan (i_measured_timespan),
        .i_prev_compact      (i_prev_compact),
        .i_div               (r_ts),
        .i_full              (full),
        .o_push              (push),
        .o_job               (f_job)
    );

    cctr_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (f_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_job      (q_job)
    );

    cctr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_vld      (nonempty),
        .i_job          (q_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_next_compact (o_next_compact),
        .o_overflow     (o_overflow)
    );
endmodule

/* src/cctr_chk.sv */
// Port-level checker for the compact target retarget block, bound to the top.
// Depends on compact_target_retarget_top_assert.svh.
`include "compact_target_retarget_top_assert.svh"

module cctr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_next_compact,
    input logic        o_overflow
);
    `CCTR_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "output word dropped while stalled")
    `CCTR_ASSERT_IMP(a_ovf_zero, o_out_valid && o_overflow, o_next_compact == 32'h0, "overflow with nonzero target")
    `CCTR_ASSERT_IMP(a_mant_pos, o_out_valid, o_next_compact[23] == 1'b0, "mantissa sign bit set")
    `CCTR_ASSERT_IMP(a_len_nz, o_out_valid && o_next_compact != 32'h0, o_next_compact[31:24] != 8'h00, "nonzero target with zero length")
endmodule

bind compact_target_retarget_top cctr_chk u_chk (.*);

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for compact_target_retarget_top: directed and random retarget words,
// checked against an in-bench predictor. Depends on cctr_pkg and the RTL top.
module tb_top;

    localparam int NBYTES = cctr_pkg::TARGET_BYTES_DEF;
    localparam int WBYTES = NBYTES + 8;
    localparam int WBITS  = WBYTES * 8;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] ADDR_TIMESPAN = 3'(4 * cctr_pkg::REG_PERIOD_LEN);
    localparam int DRAIN_CYCLES = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_measured_timespan = '0;
    logic [31:0] i_prev_compact = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_next_compact;
    logic        o_overflow;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    typedef struct packed {
        logic [31:0] compact;
        logic        ovf;
    } t_retarget;

    t_retarget   pending_targets[$];
    logic [31:0] cur_timespan = cctr_pkg::TS_RESET;
    int          n_errors = 0;
    int          n_words = 0;
    int          n_results = 0;
    int          idle_cycles = 0;
    int          in_idle_pct = 35;
    int          out_idle_pct = 35;
    bit          hold_off = 1'b0;

    compact_target_retarget_top u_top (.*);

    always #5 i_clk = ~i_clk;

    // Wide-integer model: clamp, expand, multiply, ceiling divide, re-encode.
    function automatic t_retarget predict_retarget(logic [31:0] span_in, logic [31:0] prev);
        t_retarget   r;
        logic [63:0] div, lo, hi, span;
        logic [7:0]  expo;
        logic [22:0] mant;
        logic [WBITS-1:0] val, quo;
        logic [WBITS+63:0] prod;
        int top;
        logic [WBITS+15:0] padded;
        logic [23:0] m;
        r = '0;
        div = {32'd0, cur_timespan};
        lo = div >> 2;
        hi = div << 2;
        expo = prev[31:24];
        mant = prev[22:0];
        if (expo > NBYTES) begin
            r.ovf = 1'b1;
            return r;
        end
        span = {32'd0, span_in};
        if (span < lo) span = lo;
        if (span > hi) span = hi;
        if (expo <= 3) val = WBITS'(mant >> (8 * (3 - expo)));
        else val = WBITS'(mant) << (8 * (expo - 3));
        prod = (WBITS + 64)'(val) * span;
        val = prod[WBITS-1:0];
        if (div == 0) return r;
        quo = val / WBITS'(div);
        if (val % WBITS'(div) != 0) quo = quo + 1'b1;
        top = -1;
        for (int i = WBYTES - 1; i >= 0; i--) begin
            if (quo[8*i +: 8] != 0) begin
                top = i;
                break;
            end
        end
        if (top < 0) return r;
        padded = {quo, 16'd0};
        if (quo[8*top +: 8] > 8'h7f) begin
            m = {8'd0, padded[8*top + 8 +: 16]};
            r.compact = {8'(top + 2), m};
        end else begin
            m = padded[8*top +: 24];
            r.compact = {8'(top + 1), m};
        end
        return r;
    endfunction

    task automatic apb_write(logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_TIMESPAN; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cur_timespan = val;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_targets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_timespan(logic [31:0] val);
        wait_idle();
        apb_write(val);
    endtask

    // valid stays high after the accepting edge until the next word or an idle cycle
    task automatic send_word(logic [31:0] span, logic [31:0] prev);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_measured_timespan <= span;
        i_prev_compact <= prev;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_targets.push_back(predict_retarget(span, prev));
        n_words++;
    endtask

    function automatic logic [31:0] rand_compact();
        logic [31:0] c;
        c = $urandom;
        case ($urandom_range(9))
            0: c[31:24] = 8'($urandom_range(255));
            1, 2: c[31:24] = 8'($urandom_range(3));
            default: c[31:24] = 8'($urandom_range(NBYTES));
        endcase
        return c;
    endfunction

    function automatic logic [31:0] rand_span();
        case ($urandom_range(5))
            0: return $urandom;
            1: return (cur_timespan >> 2) - 32'($urandom_range(3));
            2: return cur_timespan << 2;
            default: return cur_timespan / 4 + $urandom_range(cur_timespan);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] spans[6];
        logic [31:0] prevs[8];
        spans = '{32'd0, 32'd302400, 32'd1209600, 32'd4838400, 32'hffffffff, 32'd1};
        prevs = '{32'h00000000, 32'h01ffffff, 32'h037fffff, 32'h1d00ffff,
                  32'h20800001, 32'h21123456, 32'hff7fffff, 32'h04008000};
        foreach (prevs[i]) send_word(spans[i % 6], prevs[i]);
        foreach (spans[i]) send_word(spans[i], 32'h1b0404cb);
        send_word(32'd1209599, 32'h02008000);
        send_word(32'd1209601, 32'h207fffff);
    endtask

    task automatic test_timespan_extremes();
        set_timespan(32'd1);
        for (int i = 0; i < 12; i++) send_word($urandom_range(9), rand_compact());
        set_timespan(32'hffffffff);
        for (int i = 0; i < 12; i++) send_word($urandom, rand_compact());
        set_timespan(32'd0);
        for (int i = 0; i < 8; i++) send_word($urandom, rand_compact());
        set_timespan(cctr_pkg::TS_RESET);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 400 == 399) set_timespan($urandom_range(3) == 0 ?
                32'($urandom_range(100)) : $urandom);
            send_word(rand_span(), rand_compact());
        end
    endtask

    task automatic test_no_idle(int count);
        in_idle_pct = 0;
        out_idle_pct = 0;
        test_random(count);
        in_idle_pct = 35;
        out_idle_pct = 35;
    endtask

    // more words than the pipeline and queue hold, so the input stalls
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                in_idle_pct = 0;
                test_random(200);
                i_in_valid <= 1'b0;
                in_idle_pct = 35;
            end
        join
    endtask

    // result checker and receiver idling
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_retarget exp_t;
            n_results++;
            if (pending_targets.size() == 0) begin
                $error("unexpected word: next_compact=%h overflow=%b",
                       o_next_compact, o_overflow);
                n_errors++;
            end else begin
                exp_t = pending_targets.pop_front();
                if (o_next_compact !== exp_t.compact) begin
                    $error("next_compact exp %h got %h", exp_t.compact, o_next_compact);
                    n_errors++;
                end
                if (o_overflow !== exp_t.ovf) begin
                    $error("overflow exp %b got %b", exp_t.ovf, o_overflow);
                    n_errors++;
                end
            end
        end
        i_out_ready <= !hold_off && ($urandom_range(99) >= out_idle_pct);
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAIL compact_target_retarget_top");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_timespan_extremes();
        test_backpressure();
        test_random(900);
        test_no_idle(600);
        wait_idle();
        if (pending_targets.size() != 0) n_errors++;
        $display("Sent %0d words, checked %0d results, timespans from 0 to max.",
                 n_words, n_results);
        if (n_errors == 0) $display("PASS compact_target_retarget_top");
        else $display("FAIL compact_target_retarget_top");
        $finish;
    end
endmodule

/* compact_target_retarget_top.f */
+incdir+src
src/cctr_pkg.sv
src/cctr_front.sv
src/cctr_fifo.sv
src/cctr_div.sv
src/cctr_back.sv
src/compact_target_retarget_top.sv
src/cctr_chk.sv
test/tb_top.sv
